### src/hed_pkg.sv
// ============================================================================
// Hamming codec package
// Shared types, constants and bit-placement functions for the Hamming
// single-error-correcting encoder and decoder.
// ============================================================================
`timescale 1ns / 1ps

package hed_pkg;

    localparam int WORD_BITS = 64;
    localparam int PC_W      = 3;
    localparam int NUM_PC    = 1 << PC_W;
    localparam int NUM_CHK   = $clog2(WORD_BITS) + 1;
    localparam int SYN_W     = NUM_CHK;

    localparam logic [PC_W-1:0] PC_RESET = PC_W'(7);

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                opcode;
        logic [WORD_BITS-1:0]   word_in;
    } t_hed_in;

    typedef struct packed {
        logic [WORD_BITS-1:0]   word_out;
        logic                   error_found;
    } t_hed_out;

    // True when 1-based position pos holds a parity bit for count pc.
    function automatic logic is_check_pos(input int pos, input int pc);
        return ((pos & (pos - 1)) == 0) && (pos < (1 << pc));
    endfunction

    // Places data bits, lowest first, into the data positions in order.
    function automatic logic [WORD_BITS-1:0] scatter(input logic [WORD_BITS-1:0] data,
                                                     input int pc);
        logic [WORD_BITS-1:0] res;
        int                   di;
        res = '0;
        di  = 0;
        for (int pos = 1; pos <= WORD_BITS; pos++) begin
            if (!is_check_pos(pos, pc)) begin
                res[pos-1] = data[di];
                di++;
            end
        end
        return res;
    endfunction

    // Collects the data positions back to the low end; upper bits are zero.
    function automatic logic [WORD_BITS-1:0] gather(input logic [WORD_BITS-1:0] code,
                                                    input int pc);
        logic [WORD_BITS-1:0] res;
        int                   di;
        res = '0;
        di  = 0;
        for (int pos = 1; pos <= WORD_BITS; pos++) begin
            if (!is_check_pos(pos, pc)) begin
                res[di] = code[pos-1];
                di++;
            end
        end
        return res;
    endfunction

    // Positions whose 1-based index has bit k set.
    function automatic logic [WORD_BITS-1:0] check_mask(input int k);
        logic [WORD_BITS-1:0] m;
        m = '0;
        for (int j = 1; j <= WORD_BITS; j++) begin
            m[j-1] = ((j >> k) & 1) != 0;
        end
        return m;
    endfunction

    // XOR over each check group, the parity position itself included.
    function automatic logic [NUM_CHK-1:0] check_bits(input logic [WORD_BITS-1:0] w);
        logic [NUM_CHK-1:0] c;
        for (int k = 0; k < NUM_CHK; k++) begin
            c[k] = ^(w & check_mask(k));
        end
        return c;
    endfunction

endpackage

### src/hed_encoder.sv
// ============================================================================
// Hamming encoder
// Scatters the data word into the data positions and fills in the active
// parity bits.
// ============================================================================
`timescale 1ns / 1ps

module hed_encoder (
    input  logic [hed_pkg::WORD_BITS-1:0] i_word,
    input  logic [hed_pkg::PC_W-1:0]      i_parity_count,
    output hed_pkg::t_hed_out             o_result
);
    import hed_pkg::*;

    logic [WORD_BITS-1:0] cand [NUM_PC];
    logic [WORD_BITS-1:0] spread;
    logic [NUM_CHK-1:0]   chk;
    logic [WORD_BITS-1:0] code;

    always_comb begin
        for (int c = 0; c < NUM_PC; c++) begin
            cand[c] = scatter(i_word, c);
        end
        spread = cand[i_parity_count];
        chk    = check_bits(spread);
        code   = spread;
        for (int k = 0; k < NUM_CHK; k++) begin
            if (k < int'(i_parity_count)) begin
                code[(1 << k) - 1] = chk[k];
            end
        end
    end

    assign o_result.word_out    = code;
    assign o_result.error_found = 1'b0;

endmodule

### src/hed_decoder.sv
// ============================================================================
// Hamming decoder
// Builds the syndrome, corrects a single in-range bit error and gathers the
// data bits to the low end of the result.
// ============================================================================
`timescale 1ns / 1ps

module hed_decoder (
    input  logic [hed_pkg::WORD_BITS-1:0] i_word,
    input  logic [hed_pkg::PC_W-1:0]      i_parity_count,
    output hed_pkg::t_hed_out             o_result
);
    import hed_pkg::*;

    logic [NUM_CHK-1:0]   chk;
    logic [SYN_W-1:0]     syn;
    logic [WORD_BITS-1:0] fix;
    logic [WORD_BITS-1:0] fixed_word;
    logic [WORD_BITS-1:0] cand [NUM_PC];

    always_comb begin
        chk = check_bits(i_word);
        for (int k = 0; k < NUM_CHK; k++) begin
            syn[k] = chk[k] && (k < int'(i_parity_count));
        end
        for (int pos = 1; pos <= WORD_BITS; pos++) begin
            fix[pos-1] = (syn == SYN_W'(pos));
        end
        fixed_word = i_word ^ fix;
        for (int c = 0; c < NUM_PC; c++) begin
            cand[c] = gather(fixed_word, c);
        end
    end

    assign o_result.word_out    = cand[i_parity_count];
    assign o_result.error_found = |syn;

endmodule

### src/hamming_encode_decode.sv
// ============================================================================
// Hamming encode/decode top level
// Each accepted start strobes a result on o_done via the input and result registers.
// Throughput: one transfer per cycle; busy is never raised.
// Timing is set by the input register, one XOR-tree pass and the result
// register; the receiver cannot stall the strobe.
// Reset: synchronous, active low; clears the pipeline valids and sets the
// parity count to seven.
// ============================================================================
`timescale 1ns / 1ps

module hamming_encode_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  hed_pkg::t_hed_in           i_cmd,
    input  logic                       i_cfg_we,
    input  logic [hed_pkg::PC_W-1:0]   i_cfg_wdata,
    output logic                       o_done,
    output hed_pkg::t_hed_out          o_result
);
    import hed_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic            r_in_vld;
    t_hed_in         r_in;
    logic            r_out_vld;
    t_hed_out        r_out;
    t_hed_out        enc_res;
    t_hed_out        dec_res;
    t_hed_out        n_out;

    assign busy = 1'b0;

    hed_encoder u_encoder (
        .i_word         (r_in.word_in),
        .i_parity_count (r_pc),
        .o_result       (enc_res)
    );

    hed_decoder u_decoder (
        .i_word         (r_in.word_in),
        .i_parity_count (r_pc),
        .o_result       (dec_res)
    );

    always_comb begin
        case (r_in.opcode)
            OP_ENCODE: n_out = enc_res;
            OP_DECODE: n_out = dec_res;
            default:   n_out = enc_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= PC_RESET;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
            end
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_cmd;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_done   = r_out_vld;
    assign o_result = r_out;

`ifndef SYNTH
    // Every accepted transfer yields exactly one result strobe.
    a_valid_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> o_done)
        else $error("accepted transfer produced no result");

    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |=> !o_done)
        else $error("result strobe without an accepted transfer");

    // Encoding never reports an error.
    a_encode_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_in.opcode == OP_ENCODE) |=> !o_result.error_found)
        else $error("encode result flagged an error");

    // With no parity bits the decoder passes the word through unchanged.
    a_zero_pc_copy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_in.opcode == OP_DECODE && r_pc == '0) |=>
        (!o_result.error_found && o_result.word_out == $past(r_in.word_in)))
        else $error("decode with no parity bits altered the word");
`endif

endmodule

### sim/hed_checker.sv
// ============================================================================
// Hamming codec result checker
// Watches the command, configuration and result channels of the codec,
// predicts every result from its own model of the encoder and decoder,
// and compares each result field by field in arrival order.
// ============================================================================
`timescale 1ns / 1ps

module hed_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  hed_pkg::t_hed_in           i_cmd,
    input  logic                       i_cfg_we,
    input  logic [hed_pkg::PC_W-1:0]   i_cfg_wdata,
    input  logic                       i_done,
    input  hed_pkg::t_hed_out          i_result,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);

    import hed_pkg::*;

    hed_pkg::t_hed_out     expected_codec_results[$];
    logic [PC_W-1:0]       parity_count_model;
    int                    fail_count    = 0;
    int                    pending_count = 0;
    int                    checked_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;
    assign o_checked    = checked_count;

    function automatic bit parity_slot(input int pos, input int pcount);
        return ($countones(pos) == 1) && (pos < (1 << pcount));
    endfunction

    function automatic bit group_xor(input logic [WORD_BITS-1:0] w, input int p);
        bit acc;
        acc = 1'b0;
        for (int j = 1; j <= WORD_BITS; j++) begin
            if (((j & p) != 0) && (j != p)) begin
                acc ^= w[j-1];
            end
        end
        return acc;
    endfunction

    function automatic t_hed_out predict_codec(input t_hed_in cmd, input int pcount);
        t_hed_out             r;
        logic [WORD_BITS-1:0] w;
        logic [WORD_BITS-1:0] res;
        int                   syn;
        int                   d;
        w             = cmd.word_in;
        res           = '0;
        syn           = 0;
        d             = 0;
        r.error_found = 1'b0;
        if (cmd.opcode == OP_ENCODE) begin
            for (int pos = 1; pos <= WORD_BITS; pos++) begin
                if (!parity_slot(pos, pcount)) begin
                    res[pos-1] = w[d];
                    d++;
                end
            end
            for (int p = 1; p <= WORD_BITS; p = p << 1) begin
                if (parity_slot(p, pcount) && group_xor(res, p)) begin
                    res[p-1] = 1'b1;
                end
            end
        end else begin
            for (int p = 1; p <= WORD_BITS; p = p << 1) begin
                if (parity_slot(p, pcount) && (group_xor(w, p) != w[p-1])) begin
                    syn += p;
                end
            end
            if (syn != 0) begin
                r.error_found = 1'b1;
                if (syn <= WORD_BITS) begin
                    w[syn-1] = ~w[syn-1];
                end
            end
            for (int pos = 1; pos <= WORD_BITS; pos++) begin
                if (!parity_slot(pos, pcount)) begin
                    res[d] = w[pos-1];
                    d++;
                end
            end
        end
        r.word_out = res;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_hed_out want;
        if (!i_rst_n) begin
            expected_codec_results.delete();
            parity_count_model = PC_RESET;
        end else begin
            if (i_done) begin
                if (expected_codec_results.size() == 0) begin
                    report_mismatch("result strobe with no transfer outstanding");
                end else begin
                    want = expected_codec_results.pop_front();
                    checked_count++;
                    if (i_result.word_out !== want.word_out) begin
                        report_mismatch($sformatf("word_out %h, predicted %h",
                                                  i_result.word_out, want.word_out));
                    end
                    if (i_result.error_found !== want.error_found) begin
                        report_mismatch($sformatf("error_found %b, predicted %b",
                                                  i_result.error_found, want.error_found));
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_codec_results.push_back(predict_codec(i_cmd, parity_count_model));
            end
            if (i_cfg_we) begin
                parity_count_model = i_cfg_wdata;
            end
        end
        pending_count = expected_codec_results.size();
    end

endmodule

### sim/testbench.sv
// ============================================================================
// Hamming codec testbench
// Drives directed and random encode and decode commands into the codec
// across several parity-count settings, feeds captured codewords back with
// injected bit errors, and reports the verdict from the checker.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    import hed_pkg::*;

    localparam int                   WATCHDOG_LIMIT  = 2000;
    localparam int                   POOL_DEPTH      = 32;
    localparam logic [WORD_BITS-1:0] ALL_PARITY_BITS = 64'h8000_0000_8000_808B;
    localparam logic [WORD_BITS-1:0] SYN_65_BITS     = 64'h8000_0000_0000_0001;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_hed_in               i_cmd;
    logic                  i_cfg_we;
    logic [PC_W-1:0]       i_cfg_wdata;
    logic                  o_done;
    t_hed_out              o_result;

    int                    fail_count;
    int                    pending_count;
    int                    checked_count;
    int                    quiet_cycles;
    int                    n_encode;
    int                    n_decode;
    int                    n_reused;
    int                    n_settings;
    logic [WORD_BITS-1:0]  codeword_pool[$];
    t_opcode               ops_in_flight[$];

    hamming_encode_decode DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    hed_checker codec_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Encoded results are kept so later decodes can start from real codewords.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done && (ops_in_flight.size() > 0)) begin
                if (ops_in_flight.pop_front() == OP_ENCODE) begin
                    codeword_pool.push_back(o_result.word_out);
                    if (codeword_pool.size() > POOL_DEPTH) begin
                        void'(codeword_pool.pop_front());
                    end
                end
            end
            if (start && !busy) begin
                ops_in_flight.push_back(i_cmd.opcode);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [WORD_BITS-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_cmd(input t_opcode op, input logic [WORD_BITS-1:0] w);
        t_hed_in cmd;
        cmd.opcode  = op;
        cmd.word_in = w;
        start <= 1'b1;
        i_cmd <= cmd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        if (op == OP_ENCODE) n_encode++;
        else n_decode++;
    endtask

    task automatic pause_cmds(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic set_parity_count(input logic [PC_W-1:0] pcount);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= pcount;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        codeword_pool.delete();
        n_settings++;
    endtask

    // Decode a stored codeword with none, one, two or scattered bit errors.
    task automatic send_corrupted_codeword();
        logic [WORD_BITS-1:0] w;
        int                   bit_a;
        int                   bit_b;
        if (codeword_pool.size() == 0) begin
            send_cmd(OP_DECODE, rand64());
        end else begin
            w     = codeword_pool[$urandom_range(0, codeword_pool.size() - 1)];
            bit_a = $urandom_range(0, WORD_BITS - 1);
            bit_b = $urandom_range(0, WORD_BITS - 1);
            case ($urandom_range(0, 3))
                0: ;
                1: w[bit_a] = ~w[bit_a];
                2: begin
                    w[bit_a] = ~w[bit_a];
                    w[bit_b] = ~w[bit_b];
                end
                default: w ^= rand64() & rand64() & rand64();
            endcase
            n_reused++;
            send_cmd(OP_DECODE, w);
        end
    endtask

    task automatic run_random_phase(input logic [PC_W-1:0] pcount, input int items,
                                    input int idle_pct);
        int                   kind;
        logic [WORD_BITS-1:0] data;
        set_parity_count(pcount);
        for (int i = 0; i < items; i++) begin
            if ((idle_pct > 0) && ($urandom_range(0, 99) < idle_pct)) begin
                pause_cmds($urandom_range(1, 13));
            end
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                data = rand64();
                if (kind < 10) data = data >> $urandom_range(0, WORD_BITS - 1);
                send_cmd(OP_ENCODE, data);
            end else if (kind < 85) begin
                send_corrupted_codeword();
            end else begin
                send_cmd(OP_DECODE, rand64());
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        n_encode    = 0;
        n_decode    = 0;
        n_reused    = 0;
        n_settings  = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Seven parity bits after reset; the top data bits do not fit.
        send_cmd(OP_ENCODE, 64'h0);
        send_cmd(OP_ENCODE, '1);
        send_cmd(OP_ENCODE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_cmd(OP_ENCODE, 64'h5555_5555_5555_5555);
        send_cmd(OP_ENCODE, 64'h8000_0000_0000_0000);
        send_cmd(OP_ENCODE, 64'h01FF_FFFF_FFFF_FFFF);
        drain_results();
        send_cmd(OP_DECODE, 64'h0);
        send_cmd(OP_DECODE, '1);
        send_cmd(OP_DECODE, codeword_pool[1]);
        send_cmd(OP_DECODE, codeword_pool[1] ^ 64'h1);
        send_cmd(OP_DECODE, codeword_pool[1] ^ 64'h8000_0000_0000_0000);
        send_cmd(OP_DECODE, codeword_pool[2] ^ 64'h4);
        send_cmd(OP_DECODE, codeword_pool[2] ^ ALL_PARITY_BITS);
        send_cmd(OP_DECODE, codeword_pool[3] ^ SYN_65_BITS);
        send_cmd(OP_DECODE, codeword_pool[3] ^ 64'h0000_0100_0000_0020);

        // With no parity bits both directions pass the word through.
        set_parity_count(3'd0);
        send_cmd(OP_ENCODE, rand64());
        send_cmd(OP_DECODE, rand64());
        send_cmd(OP_DECODE, '1);

        run_random_phase(3'd1, 136, 15);
        run_random_phase(3'd7, 136, 0);
        run_random_phase(3'd0, 136, 30);
        run_random_phase(3'd4, 136, 15);
        run_random_phase(3'd2, 136, 40);
        run_random_phase(3'd6, 136, 0);
        run_random_phase(3'd3, 136, 15);
        run_random_phase(3'd5, 136, 30);
        run_random_phase(3'd7, 136, 0);

        drain_results();
        repeat (4) @(posedge i_clk);

        $display("Run covered %0d encodes and %0d decodes (%0d on stored codewords) over",
                 n_encode, n_decode, n_reused);
        $display("%0d parity-count writes, with %0d results checked.", n_settings,
                 checked_count);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
